[rtl/core/brfa_pkg.sv]
package brfa_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  // One table entry: a free range [start, start + len).
  typedef struct packed {
    logic  valid;
    word_t start;
    word_t len;
  } entry_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_UPDATE = 5'b01000,
    S_RESP   = 5'b10000
  } state_e;

endpackage

[rtl/core/brfa_cell.sv]
// One table entry. Entries shift toward cell zero as a circular row.
module brfa_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  brfa_pkg::entry_t  entry_i,
  input  logic              load_i,
  input  brfa_pkg::entry_t  load_entry_i,
  output brfa_pkg::entry_t  entry_o
);

  logic            valid_q;
  brfa_pkg::word_t start_q;
  brfa_pkg::word_t len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= load_entry_i.valid;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      start_q <= load_entry_i.start;
      len_q   <= load_entry_i.len;
    end else if (shift_i) begin
      start_q <= entry_i.start;
      len_q   <= entry_i.len;
    end
  end

  assign entry_o = '{valid: valid_q, start: start_q, len: len_q};

endmodule

[rtl/core/best_fit_range_allocator_core.sv]
// Channel | Direction | Signals
// cfg     | in        | cfg_valid_i, cfg_ready_o, total_size_i
// in      | in        | in_valid_i, in_ready_o, operation_i, block_offset_i, request_size_i
// out     | out       | out_valid_o, out_ready_i, result_offset_o, status_o, free_units_o
//
// Each word that changes the table passes through scan, decide, update pass and
// response; a rejected word skips the update pass.
// The circular row of entry cells rotates one entry past the head comparator
// per cycle, once to search and, when the table changes, once to write back.
// Reset clears all valid bits at once; no clearing pass is needed.
// A stalled output holds the block in its response state; a new word is taken
// once the block has returned to idle after the response register is loaded.
module best_fit_range_allocator_core #(
  parameter int unsigned MAX_RANGES = 64,
  parameter int unsigned ADDR_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] total_size_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [31:0] block_offset_i,
  input  logic [31:0] request_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_offset_o,
  output logic [1:0]  status_o,
  output logic [31:0] free_units_o
);

  localparam int unsigned IdxW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_RANGES - 1);
  localparam logic [63:0] AddrMask = (64'd1 << ADDR_BITS) - 64'd1;

  brfa_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]  k_q;

  brfa_pkg::entry_t row [MAX_RANGES];
  brfa_pkg::entry_t head, head_mod;
  logic             shift;
  logic             cfg_load;
  brfa_pkg::entry_t init_entry;
  brfa_pkg::word_t  cfg_sat;

  // Request registers.
  logic            op_q;
  brfa_pkg::word_t off_q, size_q;
  logic [32:0]     end_w;

  // Scan results.
  logic            best_found_q, prev_found_q, next_found_q, slot_found_q, ovl_q;
  logic [IdxW-1:0] best_idx_q, prev_idx_q, next_idx_q, slot_idx_q;
  brfa_pkg::word_t best_len_q, best_start_q, next_len_q;

  brfa_pkg::status_e status_q, status_d;
  brfa_pkg::word_t   free_total_q;

  logic            out_valid_q;
  brfa_pkg::word_t res_off_q, res_free_q;
  brfa_pkg::status_e res_st_q;

  logic in_acc, cfg_acc, out_load;

  assign in_ready_o  = (state_q == brfa_pkg::S_IDLE);
  assign cfg_ready_o = (state_q == brfa_pkg::S_IDLE);
  assign in_acc  = in_valid_i && in_ready_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;

  // A total above the address space saturates to its top.
  assign cfg_sat    = ({32'd0, total_size_i} > AddrMask) ? AddrMask[31:0] : total_size_i;
  assign init_entry = '{valid: (cfg_sat != '0), start: '0, len: cfg_sat};
  assign cfg_load   = cfg_acc;

  assign shift = (state_q == brfa_pkg::S_SCAN) || (state_q == brfa_pkg::S_UPDATE);
  assign head  = row[0];

  // The row is circular: the head entry, possibly rewritten, re-enters at the tail.
  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    brfa_pkg::entry_t nb;
    if (i == MAX_RANGES - 1) begin : g_tail
      assign nb = head_mod;
    end else begin : g_mid
      assign nb = row[i+1];
    end
    brfa_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_i      (shift),
      .entry_i      (nb),
      .load_i       (cfg_load),
      .load_entry_i ((i == 0) ? init_entry : '0),
      .entry_o      (row[i])
    );
  end

  assign end_w = {1'b0, off_q} + {1'b0, size_q};

  // Scan step on the head entry.
  logic [32:0] head_end;
  logic        fit_better;
  assign head_end   = {1'b0, head.start} + {1'b0, head.len};
  assign fit_better = head.valid && (head.len >= size_q) &&
                      (!best_found_q || (head.len < best_len_q) ||
                       ((head.len == best_len_q) && (head.start < best_start_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_found_q <= 1'b0;
      prev_found_q <= 1'b0;
      next_found_q <= 1'b0;
      slot_found_q <= 1'b0;
      ovl_q        <= 1'b0;
    end else if (in_acc) begin
      best_found_q <= 1'b0;
      prev_found_q <= 1'b0;
      next_found_q <= 1'b0;
      slot_found_q <= 1'b0;
      ovl_q        <= 1'b0;
    end else if (state_q == brfa_pkg::S_SCAN) begin
      if (op_q == brfa_pkg::OP_ALLOC) begin
        if (fit_better) begin
          best_found_q <= 1'b1;
        end
      end else if (!head.valid) begin
        if (!slot_found_q) begin
          slot_found_q <= 1'b1;
        end
      end else begin
        if (({1'b0, head.start} < end_w) && ({1'b0, off_q} < head_end)) begin
          ovl_q <= 1'b1;
        end
        if (head_end == {1'b0, off_q}) begin
          prev_found_q <= 1'b1;
        end
        if ({1'b0, head.start} == end_w) begin
          next_found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= operation_i;
      off_q  <= block_offset_i;
      size_q <= request_size_i;
    end
    if (state_q == brfa_pkg::S_SCAN) begin
      if (op_q == brfa_pkg::OP_ALLOC) begin
        if (fit_better) begin
          best_idx_q   <= k_q;
          best_len_q   <= head.len;
          best_start_q <= head.start;
        end
      end else if (!head.valid) begin
        if (!slot_found_q) begin
          slot_idx_q <= k_q;
        end
      end else begin
        if (head_end == {1'b0, off_q}) begin
          prev_idx_q <= k_q;
        end
        if ({1'b0, head.start} == end_w) begin
          next_idx_q <= k_q;
          next_len_q <= head.len;
        end
      end
    end
  end

  // Outcome once the whole table has been seen.
  always_comb begin
    status_d = brfa_pkg::ST_OK;
    if (size_q == '0) begin
      status_d = brfa_pkg::ST_ZERO;
    end else if (op_q == brfa_pkg::OP_ALLOC) begin
      if (!best_found_q) begin
        status_d = brfa_pkg::ST_NOFIT;
      end
    end else if (({31'd0, end_w} > AddrMask) || ovl_q) begin
      status_d = brfa_pkg::ST_NOFIT;
    end else if (!prev_found_q && !next_found_q && !slot_found_q) begin
      status_d = brfa_pkg::ST_FULL;
    end
  end

  // Write-back of the head entry on the update pass.
  always_comb begin
    head_mod = head;
    if (state_q == brfa_pkg::S_UPDATE) begin
      if (op_q == brfa_pkg::OP_ALLOC) begin
        if (k_q == best_idx_q) begin
          if (head.len == size_q) begin
            head_mod = '0;
          end else begin
            head_mod.start = head.start + size_q;
            head_mod.len   = head.len - size_q;
          end
        end
      end else if (prev_found_q) begin
        if (k_q == prev_idx_q) begin
          head_mod.len = head.len + size_q + (next_found_q ? next_len_q : '0);
        end else if (next_found_q && (k_q == next_idx_q)) begin
          head_mod = '0;
        end
      end else if (next_found_q) begin
        if (k_q == next_idx_q) begin
          head_mod.start = off_q;
          head_mod.len   = head.len + size_q;
        end
      end else if (k_q == slot_idx_q) begin
        head_mod = '{valid: 1'b1, start: off_q, len: size_q};
      end
    end
  end

  assign out_load = (state_q == brfa_pkg::S_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      brfa_pkg::S_IDLE: begin
        if (in_acc) state_d = brfa_pkg::S_SCAN;
      end
      brfa_pkg::S_SCAN: begin
        if (k_q == LastIdx) state_d = brfa_pkg::S_DECIDE;
      end
      brfa_pkg::S_DECIDE: begin
        state_d = (status_d == brfa_pkg::ST_OK) ? brfa_pkg::S_UPDATE : brfa_pkg::S_RESP;
      end
      brfa_pkg::S_UPDATE: begin
        if (k_q == LastIdx) state_d = brfa_pkg::S_RESP;
      end
      brfa_pkg::S_RESP: begin
        if (out_load) state_d = brfa_pkg::S_IDLE;
      end
      default: state_d = brfa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= brfa_pkg::S_IDLE;
      k_q          <= '0;
      free_total_q <= '0;
      status_q     <= brfa_pkg::ST_OK;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (shift) begin
        k_q <= (k_q == LastIdx) ? '0 : k_q + 1'b1;
      end
      if (cfg_acc) begin
        free_total_q <= cfg_sat;
      end else if ((state_q == brfa_pkg::S_DECIDE) && (status_d == brfa_pkg::ST_OK)) begin
        free_total_q <= (op_q == brfa_pkg::OP_ALLOC) ? free_total_q - size_q
                                                     : free_total_q + size_q;
      end
      if (state_q == brfa_pkg::S_DECIDE) begin
        status_q <= status_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_st_q   <= status_q;
      res_free_q <= free_total_q;
      res_off_q  <= ((op_q == brfa_pkg::OP_ALLOC) && (status_q == brfa_pkg::ST_OK))
                    ? best_start_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_offset_o = res_off_q;
  assign status_o        = res_st_q;
  assign free_units_o    = res_free_q;

endmodule

[rtl/core/brfa_checker.sv]
module brfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] result_offset_o,
  input logic [1:0]  status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !cfg_ready_o)
    else $error("new word or config taken while a word is in progress");

  a_fail_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != brfa_pkg::ST_OK) |-> result_offset_o == 32'd0)
    else $error("nonzero offset on a failed request");

  a_ready_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == cfg_ready_o)
    else $error("input and config ready disagree");

endmodule

bind best_fit_range_allocator_core brfa_checker u_brfa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .result_offset_o (result_offset_o),
  .status_o        (status_o)
);
